FILE: rtl/assert_macros.svh
// Assertion macros shared by the RTL of the I2C register access master.
// No dependencies; files that assert include this header by its bare name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Property must hold at every clock edge outside reset.
`define I2CM_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Condition must never be seen at a clock edge outside reset.
`define I2CM_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define I2CM_ASSERT(lbl, clk, rst_n, prop, msg)
`define I2CM_NEVER(lbl, clk, rst_n, cond, msg)
`endif

`endif

FILE: rtl/i2cm_pkg.sv
// Shared types and constants of the I2C register access master.
// No dependencies; used by i2cm_seq and i2c_master_register_access.
package i2cm_pkg;

    localparam int COUNT_BITS = 8;
    localparam int HALF_BITS  = 16;
    localparam int CFG_INDEX_BITS = 1;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_WRITE_HALF = 1'b0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_READ_HALF  = 1'b1;

    localparam logic [HALF_BITS-1:0] HALF_RESET = 16'd5;

    localparam logic [7:0] ADDR_WRITE_MASK = 8'hFE;
    localparam logic [7:0] ADDR_READ_BIT   = 8'h01;

    typedef enum logic [4:0] {
        PH_IDLE        = 5'd0,
        PH_ST_SDA_LOW  = 5'd1,
        PH_ST_SCL_LOW  = 5'd2,
        PH_RS_SDA_HIGH = 5'd3,
        PH_RS_SCL_HIGH = 5'd4,
        PH_RS_SDA_LOW  = 5'd5,
        PH_RS_SCL_LOW  = 5'd6,
        PH_ADDRW_LOW   = 5'd7,
        PH_ADDRW_HIGH  = 5'd8,
        PH_REG_LOW     = 5'd9,
        PH_REG_HIGH    = 5'd10,
        PH_ADDRR_LOW   = 5'd11,
        PH_ADDRR_HIGH  = 5'd12,
        PH_DATA_LOW    = 5'd13,
        PH_DATA_HIGH   = 5'd14,
        PH_RX_LOW      = 5'd15,
        PH_RX_HIGH     = 5'd16,
        PH_SP_SDA_LOW  = 5'd17,
        PH_SP_SCL_HIGH = 5'd18,
        PH_SP_SDA_HIGH = 5'd19
    } t_phase;

    // One tick of input: command fields plus the sampled SDA level.
    typedef struct packed {
        logic       cmd_valid;
        logic       opcode;
        logic [7:0] device_address;
        logic [7:0] register_address;
        logic [7:0] byte_total;
        logic [7:0] write_byte_in;
        logic       sda_in;
    } t_cmd;

    // One tick of result.
    typedef struct packed {
        logic       scl_out;
        logic       sda_out;
        logic       sda_drive_enable;
        logic       busy_res;
        logic       data_request;
        logic [7:0] read_byte_out;
        logic       read_valid;
        logic       done_res;
        logic [7:0] bytes_done;
    } t_result;

endpackage

FILE: rtl/i2cm_seq.sv
// Bus sequencer of the I2C register access master: phase state, bit and
// byte counters, half-period timer and per-tick pin/result logic. Uses i2cm_pkg.
`include "assert_macros.svh"

module i2cm_seq (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_step,
    input  i2cm_pkg::t_cmd                        i_cmd,
    input  logic [i2cm_pkg::HALF_BITS-1:0]        i_wr_half,
    input  logic [i2cm_pkg::HALF_BITS-1:0]        i_rd_half,
    output i2cm_pkg::t_result                     o_res
);
    import i2cm_pkg::*;

    t_phase                r_phase,    n_phase;
    logic [3:0]            r_bit_idx,  n_bit_idx;
    logic [7:0]            r_shift,    n_shift;
    logic [COUNT_BITS-1:0] r_byte_cnt, n_byte_cnt;
    logic [HALF_BITS-1:0]  r_delay,    n_delay;
    logic                  r_op,       n_op;
    logic [7:0]            r_dev,      n_dev;
    logic [7:0]            r_reg,      n_reg;
    logic [7:0]            r_total,    n_total;

    logic                  w_rx;
    logic [HALF_BITS-1:0]  w_len;
    logic [HALF_BITS-1:0]  w_len1;
    logic [HALF_BITS:0]    w_delay_p1;
    logic                  w_hit;
    logic [HALF_BITS-1:0]  w_delay_nx;
    logic [COUNT_BITS-1:0] w_total_m;
    logic [COUNT_BITS-1:0] w_tot;
    logic [COUNT_BITS-1:0] w_cnt_inc;
    logic                  w_bit_data;
    logic                  w_tx_bit;
    logic [7:0]            w_rx_shift;

    // Half-period timer: a zero register value acts as one.
    assign w_rx       = (r_phase == PH_RX_LOW) || (r_phase == PH_RX_HIGH);
    assign w_len      = w_rx ? i_rd_half : i_wr_half;
    assign w_len1     = (w_len == '0) ? HALF_BITS'(1) : w_len;
    assign w_delay_p1 = {1'b0, r_delay} + (HALF_BITS + 1)'(1);
    assign w_hit      = w_delay_p1 >= {1'b0, w_len1};
    assign w_delay_nx = w_hit ? '0 : w_delay_p1[HALF_BITS-1:0];

    // Byte total, zero acts as one.
    assign w_total_m  = COUNT_BITS'(r_total);
    assign w_tot      = (w_total_m == '0) ? COUNT_BITS'(1) : w_total_m;
    assign w_cnt_inc  = r_byte_cnt + COUNT_BITS'(1);

    assign w_bit_data = ~r_bit_idx[3];
    assign w_tx_bit   = r_shift[~r_bit_idx[2:0]];
    assign w_rx_shift = {r_shift[6:0], i_cmd.sda_in};

    // Next state
    always_comb begin
        n_phase    = r_phase;
        n_bit_idx  = r_bit_idx;
        n_shift    = r_shift;
        n_byte_cnt = r_byte_cnt;
        n_delay    = r_delay;
        n_op       = r_op;
        n_dev      = r_dev;
        n_reg      = r_reg;
        n_total    = r_total;
        case (r_phase)
            PH_IDLE: begin
                if (i_cmd.cmd_valid) begin
                    n_op       = i_cmd.opcode;
                    n_dev      = i_cmd.device_address;
                    n_reg      = i_cmd.register_address;
                    n_total    = i_cmd.byte_total;
                    n_byte_cnt = '0;
                    n_bit_idx  = '0;
                    n_delay    = '0;
                    n_phase    = PH_ST_SDA_LOW;
                end
            end
            PH_ST_SDA_LOW:  n_phase = PH_ST_SCL_LOW;
            PH_ST_SCL_LOW: begin
                n_phase   = PH_ADDRW_LOW;
                n_shift   = r_dev & ADDR_WRITE_MASK;
                n_bit_idx = '0;
                n_delay   = '0;
            end
            PH_RS_SDA_HIGH: n_phase = PH_RS_SCL_HIGH;
            PH_RS_SCL_HIGH: n_phase = PH_RS_SDA_LOW;
            PH_RS_SDA_LOW:  n_phase = PH_RS_SCL_LOW;
            PH_RS_SCL_LOW: begin
                n_phase   = PH_ADDRR_LOW;
                n_shift   = r_dev | ADDR_READ_BIT;
                n_bit_idx = '0;
                n_delay   = '0;
            end
            PH_ADDRW_LOW: begin
                n_delay = w_delay_nx;
                if (w_hit) n_phase = PH_ADDRW_HIGH;
            end
            PH_REG_LOW: begin
                n_delay = w_delay_nx;
                if (w_hit) n_phase = PH_REG_HIGH;
            end
            PH_ADDRR_LOW: begin
                n_delay = w_delay_nx;
                if (w_hit) n_phase = PH_ADDRR_HIGH;
            end
            PH_DATA_LOW: begin
                n_delay = w_delay_nx;
                if (w_hit) n_phase = PH_DATA_HIGH;
            end
            PH_ADDRW_HIGH: begin
                n_delay = w_delay_nx;
                if (w_hit) begin
                    if (w_bit_data) begin
                        n_bit_idx = r_bit_idx + 4'd1;
                        n_phase   = PH_ADDRW_LOW;
                    end else if (i_cmd.sda_in) begin
                        n_phase = PH_SP_SDA_LOW;
                    end else begin
                        n_phase   = PH_REG_LOW;
                        n_shift   = r_reg;
                        n_bit_idx = '0;
                    end
                end
            end
            PH_REG_HIGH: begin
                n_delay = w_delay_nx;
                if (w_hit) begin
                    if (w_bit_data) begin
                        n_bit_idx = r_bit_idx + 4'd1;
                        n_phase   = PH_REG_LOW;
                    end else if (i_cmd.sda_in) begin
                        n_phase = PH_SP_SDA_LOW;
                    end else if (r_op) begin
                        n_phase   = PH_DATA_LOW;
                        n_shift   = i_cmd.write_byte_in;
                        n_bit_idx = '0;
                    end else begin
                        n_phase = PH_RS_SDA_HIGH;
                    end
                end
            end
            PH_ADDRR_HIGH: begin
                n_delay = w_delay_nx;
                if (w_hit) begin
                    if (w_bit_data) begin
                        n_bit_idx = r_bit_idx + 4'd1;
                        n_phase   = PH_ADDRR_LOW;
                    end else begin
                        // ACK of the read address is not checked
                        n_phase   = PH_RX_LOW;
                        n_shift   = '0;
                        n_bit_idx = '0;
                    end
                end
            end
            PH_DATA_HIGH: begin
                n_delay = w_delay_nx;
                if (w_hit) begin
                    if (w_bit_data) begin
                        n_bit_idx = r_bit_idx + 4'd1;
                        n_phase   = PH_DATA_LOW;
                    end else begin
                        // A NACKed byte still counts
                        n_byte_cnt = w_cnt_inc;
                        if (i_cmd.sda_in || (w_cnt_inc >= w_tot)) begin
                            n_phase = PH_SP_SDA_LOW;
                        end else begin
                            n_phase   = PH_DATA_LOW;
                            n_shift   = i_cmd.write_byte_in;
                            n_bit_idx = '0;
                        end
                    end
                end
            end
            PH_RX_LOW: begin
                n_delay = w_delay_nx;
                if (w_hit) n_phase = PH_RX_HIGH;
            end
            PH_RX_HIGH: begin
                n_delay = w_delay_nx;
                if (w_hit) begin
                    if (w_bit_data) begin
                        n_shift   = w_rx_shift;
                        n_bit_idx = r_bit_idx + 4'd1;
                        n_phase   = PH_RX_LOW;
                        if ((r_bit_idx == 4'd7) && (r_byte_cnt < w_tot)) begin
                            n_byte_cnt = w_cnt_inc;
                        end
                    end else if (r_byte_cnt >= w_tot) begin
                        n_phase = PH_SP_SDA_LOW;
                    end else begin
                        n_phase   = PH_RX_LOW;
                        n_shift   = '0;
                        n_bit_idx = '0;
                    end
                end
            end
            PH_SP_SDA_LOW:  n_phase = PH_SP_SCL_HIGH;
            PH_SP_SCL_HIGH: n_phase = PH_SP_SDA_HIGH;
            PH_SP_SDA_HIGH: n_phase = PH_IDLE;
            default: begin
                n_phase = PH_IDLE;
                n_delay = '0;
            end
        endcase
    end

    // Outputs of this tick
    always_comb begin
        o_res                  = '0;
        o_res.scl_out          = 1'b1;
        o_res.sda_out          = 1'b1;
        o_res.sda_drive_enable = 1'b1;
        o_res.busy_res         = (r_phase != PH_IDLE);
        case (r_phase)
            PH_IDLE: ;
            PH_ST_SDA_LOW: o_res.sda_out = 1'b0;
            PH_ST_SCL_LOW: begin
                o_res.scl_out = 1'b0;
                o_res.sda_out = 1'b0;
            end
            PH_RS_SDA_HIGH: o_res.scl_out = 1'b0;
            PH_RS_SCL_HIGH: ;
            PH_RS_SDA_LOW:  o_res.sda_out = 1'b0;
            PH_RS_SCL_LOW: begin
                o_res.scl_out = 1'b0;
                o_res.sda_out = 1'b0;
            end
            PH_ADDRW_LOW, PH_REG_LOW, PH_ADDRR_LOW, PH_DATA_LOW,
            PH_ADDRW_HIGH, PH_REG_HIGH, PH_ADDRR_HIGH, PH_DATA_HIGH: begin
                o_res.scl_out = ~r_phase[0];
                if (w_bit_data) begin
                    o_res.sda_out = w_tx_bit;
                end else begin
                    o_res.sda_out          = 1'b0;
                    o_res.sda_drive_enable = 1'b0;
                end
                if ((r_phase == PH_REG_HIGH) && w_hit && !w_bit_data
                        && !i_cmd.sda_in && r_op) begin
                    o_res.data_request = 1'b1;
                end
                if ((r_phase == PH_DATA_HIGH) && w_hit && !w_bit_data
                        && !i_cmd.sda_in && (w_cnt_inc < w_tot)) begin
                    o_res.data_request = 1'b1;
                end
            end
            PH_RX_LOW, PH_RX_HIGH: begin
                o_res.scl_out = (r_phase == PH_RX_HIGH);
                if (w_bit_data) begin
                    o_res.sda_out          = 1'b0;
                    o_res.sda_drive_enable = 1'b0;
                end else begin
                    // ACK all but the last byte
                    o_res.sda_out = (r_byte_cnt >= w_tot);
                end
                if ((r_phase == PH_RX_HIGH) && w_hit && (r_bit_idx == 4'd7)) begin
                    o_res.read_valid    = 1'b1;
                    o_res.read_byte_out = w_rx_shift;
                end
            end
            PH_SP_SDA_LOW: begin
                o_res.scl_out = 1'b0;
                o_res.sda_out = 1'b0;
            end
            PH_SP_SCL_HIGH: o_res.sda_out = 1'b0;
            PH_SP_SDA_HIGH: begin
                o_res.done_res   = 1'b1;
                o_res.bytes_done = 8'(r_byte_cnt);
            end
            default: o_res.busy_res = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_IDLE;
            r_bit_idx  <= '0;
            r_shift    <= '0;
            r_byte_cnt <= '0;
            r_delay    <= '0;
            r_op       <= 1'b0;
            r_dev      <= '0;
            r_reg      <= '0;
            r_total    <= '0;
        end else if (i_step) begin
            r_phase    <= n_phase;
            r_bit_idx  <= n_bit_idx;
            r_shift    <= n_shift;
            r_byte_cnt <= n_byte_cnt;
            r_delay    <= n_delay;
            r_op       <= n_op;
            r_dev      <= n_dev;
            r_reg      <= n_reg;
            r_total    <= n_total;
        end
    end

    `I2CM_ASSERT(a_hold_without_step, i_clk, i_rst_n, !i_step |=> ($stable(r_phase) && $stable(r_delay) && $stable(r_byte_cnt)), "sequencer moved without a tick")
    `I2CM_ASSERT(a_idle_waits, i_clk, i_rst_n, (i_step && (r_phase == PH_IDLE) && !i_cmd.cmd_valid) |=> (r_phase == PH_IDLE), "left idle without a command")
    `I2CM_ASSERT(a_done_to_idle, i_clk, i_rst_n, (i_step && o_res.done_res) |=> (r_phase == PH_IDLE), "done without return to idle")
    `I2CM_NEVER(a_count_bound, i_clk, i_rst_n, (r_byte_cnt > w_tot) || (r_bit_idx > 4'd8), "byte or bit count past its limit")

endmodule

FILE: rtl/i2c_master_register_access.sv
// Top level of the I2C register access master: stream ports, configuration
// registers and result register around i2cm_seq. Uses i2cm_pkg.
//
// Usage: every word on the s_axis channel is one clock tick of the I2C bus
// sequencer. It carries the command fields (only looked at while idle), the
// next write data byte and the sampled SDA level. Each accepted word yields
// exactly one word on m_axis: SCL/SDA drive levels, SDA drive enable, busy,
// data request, received byte with its strobe, and done with the byte count.
// A register write sends START, address, register byte and data bytes; a
// register read adds a repeated START and receives bytes. Every transaction
// ends with STOP.
// Latency: the result word of a tick is presented the cycle after the tick is
// accepted. Throughput: one word per cycle; a word is taken while the result
// register is empty or being drained, so the sequencer and the output register
// form a two-stage pipe that never inserts bubbles.
// Stall: while m_axis_tready is low and a result is held, s_axis_tready drops
// and the bus state holds; no tick is lost or repeated.
// Reset (i_rst_n low, synchronous): sequencer goes idle, counters clear, both
// half-period registers return to 5, the result register empties.
// Configuration: i_cfg_we writes register i_cfg_index (0 write half period,
// 1 read half period); write only while no transaction is running.

module i2c_master_register_access (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  logic                                     s_axis_tvalid,
    output logic                                     s_axis_tready,
    // [0] cmd_valid, [8:1] device_address, [16:9] register_address,
    // [24:17] byte_total, [32:25] write_byte_in, [33] sda_in, [39:34] zero
    input  logic [39:0]                              s_axis_tdata,
    // [0] opcode
    input  logic [0:0]                               s_axis_tuser,
    output logic                                     m_axis_tvalid,
    input  logic                                     m_axis_tready,
    // [0] scl_out, [1] sda_out, [2] sda_drive_enable, [3] busy_res,
    // [4] data_request, [12:5] read_byte_out, [13] read_valid,
    // [14] done_res, [22:15] bytes_done, [23] zero
    output logic [23:0]                              m_axis_tdata,
    input  logic                                     i_cfg_we,
    input  logic [i2cm_pkg::CFG_INDEX_BITS-1:0]      i_cfg_index,
    input  logic [i2cm_pkg::HALF_BITS-1:0]           i_cfg_data
);
    import i2cm_pkg::*;

    logic [HALF_BITS-1:0] r_wr_half;
    logic [HALF_BITS-1:0] r_rd_half;
    logic                 r_out_valid;
    t_result              r_out;

    logic    w_step;
    t_cmd    w_cmd;
    t_result w_res;

    // Unpack the input word
    assign w_cmd.cmd_valid        = s_axis_tdata[0];
    assign w_cmd.opcode           = s_axis_tuser[0];
    assign w_cmd.device_address   = s_axis_tdata[8:1];
    assign w_cmd.register_address = s_axis_tdata[16:9];
    assign w_cmd.byte_total       = s_axis_tdata[24:17];
    assign w_cmd.write_byte_in    = s_axis_tdata[32:25];
    assign w_cmd.sda_in           = s_axis_tdata[33];

    // Take a word whenever the result slot is free or draining this cycle
    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign w_step        = s_axis_tvalid && s_axis_tready;

    i2cm_seq u_seq (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_step    (w_step),
        .i_cmd     (w_cmd),
        .i_wr_half (r_wr_half),
        .i_rd_half (r_rd_half),
        .o_res     (w_res)
    );

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_half <= HALF_RESET;
            r_rd_half <= HALF_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_WRITE_HALF: r_wr_half <= i_cfg_data;
                CFG_READ_HALF:  r_rd_half <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Result register: fill on a tick, empty when taken without a new tick
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_step) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step) begin
            r_out <= w_res;
        end
    end

    // Pack the result word
    assign m_axis_tvalid       = r_out_valid;
    assign m_axis_tdata[0]     = r_out.scl_out;
    assign m_axis_tdata[1]     = r_out.sda_out;
    assign m_axis_tdata[2]     = r_out.sda_drive_enable;
    assign m_axis_tdata[3]     = r_out.busy_res;
    assign m_axis_tdata[4]     = r_out.data_request;
    assign m_axis_tdata[12:5]  = r_out.read_byte_out;
    assign m_axis_tdata[13]    = r_out.read_valid;
    assign m_axis_tdata[14]    = r_out.done_res;
    assign m_axis_tdata[22:15] = r_out.bytes_done;
    assign m_axis_tdata[23]    = 1'b0;

endmodule

FILE: bench/tb_i2c_master_register_access.sv
`timescale 1ns / 1ps
// Self-checking bench for i2c_master_register_access: drives bus ticks, models SDA
// acks, predicts every result word and checks it. Needs only i2cm_pkg and the RTL.
module tb_i2c_master_register_access;
    import i2cm_pkg::*;

    localparam logic OP_READ  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    // Ack slots that a directed transfer can NACK on purpose.
    localparam int ACK_NONE    = -1;
    localparam int ACK_ADDR_WR = 0;
    localparam int ACK_REG     = 1;
    localparam int ACK_ADDR_RD = 2;
    localparam int ACK_DATA0   = 2;

    localparam logic [7:0] COUNT_MASK  = 8'((1 << COUNT_BITS) - 1);
    localparam int         CYCLE_LIMIT = 2_000_000;
    localparam int         DRAIN_LIMIT = 2000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    // [0] cmd_valid, [8:1] device_address, [16:9] register_address,
    // [24:17] byte_total, [32:25] write_byte_in, [33] sda_in, [39:34] zero
    logic [39:0] s_axis_tdata = '0;
    // [0] opcode
    logic [0:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    // [0] scl_out, [1] sda_out, [2] sda_drive_enable, [3] busy_res,
    // [4] data_request, [12:5] read_byte_out, [13] read_valid,
    // [14] done_res, [22:15] bytes_done, [23] zero
    logic [23:0] m_axis_tdata;
    logic                      i_cfg_we = 1'b0;
    logic [CFG_INDEX_BITS-1:0] i_cfg_index = '0;
    logic [HALF_BITS-1:0]      i_cfg_data = '0;

    i2c_master_register_access dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always #6 i_clk = ~i_clk;

    // Result words predicted for each accepted tick, oldest first.
    t_result pin_forecast[$];
    int      fail_count = 0;
    int      cycle_count = 0;
    int      gap_pct = 0;
    int      stall_pct = 0;

    // ------------------------------------------------------------------
    // Sequencer model: a private copy of the bus state and both half periods.
    // ------------------------------------------------------------------
    logic [15:0] wr_half = HALF_RESET;
    logic [15:0] rd_half = HALF_RESET;
    t_phase      ph_q = PH_IDLE;
    logic [3:0]  bit_q = '0;       // 0..7 data bits, 8 is the ack slot
    logic [7:0]  shift_q = '0;
    logic [7:0]  cnt_q = '0;
    logic [15:0] dly_q = '0;
    logic        cmd_op = 1'b0;
    logic [7:0]  cmd_dev = '0;
    logic [7:0]  cmd_reg = '0;
    logic [7:0]  cmd_total = '0;

    // A zero or wrapped count still moves one byte.
    function automatic logic [7:0] total_target();
        logic [7:0] t;
        t = cmd_total & COUNT_MASK;
        return (t == 8'd0) ? 8'd1 : t;
    endfunction

    // Count one tick of a half period; true on its last tick. Zero acts as one.
    function automatic bit half_elapsed(input logic [15:0] len);
        logic [16:0] lim;
        lim = (len == 16'd0) ? 17'd1 : {1'b0, len};
        if ({1'b0, dly_q} + 17'd1 >= lim) begin
            dly_q = '0;
            return 1'b1;
        end
        dly_q = dly_q + 16'd1;
        return 1'b0;
    endfunction

    function automatic void start_byte(input t_phase low_ph, input logic [7:0] b);
        ph_q    = low_ph;
        shift_q = b;
        bit_q   = '0;
        dly_q   = '0;
    endfunction

    function automatic void to_stop();
        ph_q  = PH_SP_SDA_LOW;
        dly_q = '0;
    endfunction

    // Advance the model by one accepted tick and return the pin word it drives.
    task automatic sequencer_tick(input t_cmd w, output t_result r);
        t_phase cur;
        t_phase lo;
        logic   hi;
        cur = ph_q;
        r = '0;
        r.scl_out = 1'b1;
        r.sda_out = 1'b1;
        r.sda_drive_enable = 1'b1;
        r.busy_res = (cur != PH_IDLE);
        case (cur)
            PH_IDLE: begin
                if (w.cmd_valid) begin
                    cmd_op    = w.opcode;
                    cmd_dev   = w.device_address;
                    cmd_reg   = w.register_address;
                    cmd_total = w.byte_total;
                    cnt_q     = '0;
                    bit_q     = '0;
                    dly_q     = '0;
                    ph_q      = PH_ST_SDA_LOW;
                end
            end
            PH_ST_SDA_LOW: begin
                r.sda_out = 1'b0;
                ph_q = PH_ST_SCL_LOW;
            end
            PH_ST_SCL_LOW: begin
                r.scl_out = 1'b0;
                r.sda_out = 1'b0;
                start_byte(PH_ADDRW_LOW, cmd_dev & ADDR_WRITE_MASK);
            end
            PH_RS_SDA_HIGH: begin
                r.scl_out = 1'b0;
                ph_q = PH_RS_SCL_HIGH;
            end
            PH_RS_SCL_HIGH: ph_q = PH_RS_SDA_LOW;
            PH_RS_SDA_LOW: begin
                r.sda_out = 1'b0;
                ph_q = PH_RS_SCL_LOW;
            end
            PH_RS_SCL_LOW: begin
                r.scl_out = 1'b0;
                r.sda_out = 1'b0;
                start_byte(PH_ADDRR_LOW, cmd_dev | ADDR_READ_BIT);
            end
            PH_ADDRW_LOW, PH_ADDRW_HIGH, PH_REG_LOW, PH_REG_HIGH,
            PH_ADDRR_LOW, PH_ADDRR_HIGH, PH_DATA_LOW, PH_DATA_HIGH: begin
                // Transmit: low phases are odd codes, the high half follows.
                hi = ~cur[0];
                lo = hi ? t_phase'(cur - 5'd1) : cur;
                r.scl_out = hi;
                if (bit_q < 4'd8) begin
                    r.sda_out = shift_q[3'd7 - bit_q[2:0]];
                end else begin
                    r.sda_drive_enable = 1'b0;
                    r.sda_out = 1'b0;
                end
                if (half_elapsed(wr_half)) begin
                    if (!hi) begin
                        ph_q = t_phase'(lo + 5'd1);
                    end else if (bit_q < 4'd8) begin
                        bit_q = bit_q + 4'd1;
                        ph_q = lo;
                    end else begin
                        case (lo)
                            PH_ADDRW_LOW: begin
                                if (w.sda_in) to_stop();
                                else start_byte(PH_REG_LOW, cmd_reg);
                            end
                            PH_REG_LOW: begin
                                if (w.sda_in) begin
                                    to_stop();
                                end else if (cmd_op == OP_WRITE) begin
                                    r.data_request = 1'b1;
                                    start_byte(PH_DATA_LOW, w.write_byte_in);
                                end else begin
                                    ph_q  = PH_RS_SDA_HIGH;
                                    dly_q = '0;
                                end
                            end
                            // The ack of the read address is not looked at.
                            PH_ADDRR_LOW: start_byte(PH_RX_LOW, 8'h00);
                            default: begin
                                // A NACKed data byte still counts.
                                cnt_q = (cnt_q + 8'd1) & COUNT_MASK;
                                if (w.sda_in || cnt_q >= total_target()) begin
                                    to_stop();
                                end else begin
                                    r.data_request = 1'b1;
                                    start_byte(PH_DATA_LOW, w.write_byte_in);
                                end
                            end
                        endcase
                    end
                end
            end
            PH_RX_LOW, PH_RX_HIGH: begin
                hi = (cur == PH_RX_HIGH);
                r.scl_out = hi;
                if (bit_q < 4'd8) begin
                    r.sda_drive_enable = 1'b0;
                    r.sda_out = 1'b0;
                end else begin
                    // NACK the last byte, ACK the others.
                    r.sda_out = (cnt_q >= total_target());
                end
                if (half_elapsed(rd_half)) begin
                    if (!hi) begin
                        ph_q = PH_RX_HIGH;
                    end else if (bit_q < 4'd8) begin
                        shift_q = {shift_q[6:0], w.sda_in};
                        bit_q = bit_q + 4'd1;
                        if (bit_q == 4'd8) begin
                            r.read_valid = 1'b1;
                            r.read_byte_out = shift_q;
                            if (cnt_q < total_target()) cnt_q = (cnt_q + 8'd1) & COUNT_MASK;
                        end
                        ph_q = PH_RX_LOW;
                    end else if (cnt_q >= total_target()) begin
                        to_stop();
                    end else begin
                        start_byte(PH_RX_LOW, 8'h00);
                    end
                end
            end
            PH_SP_SDA_LOW: begin
                r.scl_out = 1'b0;
                r.sda_out = 1'b0;
                ph_q = PH_SP_SCL_HIGH;
            end
            PH_SP_SCL_HIGH: begin
                r.sda_out = 1'b0;
                ph_q = PH_SP_SDA_HIGH;
            end
            PH_SP_SDA_HIGH: begin
                r.done_res = 1'b1;
                r.bytes_done = cnt_q;
                ph_q = PH_IDLE;
            end
            default: begin
                r.busy_res = 1'b0;
                ph_q  = PH_IDLE;
                dly_q = '0;
            end
        endcase
    endtask

    // ------------------------------------------------------------------
    // Stimulus side
    // ------------------------------------------------------------------

    // Drive one tick word, hold it until taken, then record its prediction.
    task automatic send_word(input t_cmd w);
        t_result r;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {6'b0, w.sda_in, w.write_byte_in, w.byte_total,
                          w.register_address, w.device_address, w.cmd_valid};
        s_axis_tuser  <= w.opcode;
        do @(posedge i_clk); while (!s_axis_tready);
        sequencer_tick(w, r);
        pin_forecast.push_back(r);
        // Random sender gap after the word.
        if (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
            s_axis_tvalid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < gap_pct);
        end
    endtask

    function automatic t_cmd random_word();
        logic [63:0] bits;
        bits = {$urandom, $urandom};
        return bits[$bits(t_cmd)-1:0];
    endfunction

    // SDA level from the addressed device: ack slots of transmitted bytes get
    // ACK unless the slot is picked for a NACK or noise hits; data is random.
    function automatic logic device_sda(input int nack_slot, input int noise_pct);
        int slot;
        if (ph_q >= PH_ADDRW_LOW && ph_q <= PH_DATA_HIGH && bit_q == 4'd8) begin
            case (ph_q)
                PH_ADDRW_LOW, PH_ADDRW_HIGH: slot = ACK_ADDR_WR;
                PH_REG_LOW, PH_REG_HIGH:     slot = ACK_REG;
                PH_ADDRR_LOW, PH_ADDRR_HIGH: slot = ACK_ADDR_RD;
                default:                     slot = ACK_DATA0 + int'(cnt_q);
            endcase
            return (slot == nack_slot) || ($urandom_range(99) < noise_pct);
        end
        return 1'($urandom_range(1));
    endfunction

    // Ticks with no command while the bus is idle.
    task automatic idle_ticks(input int n);
        t_cmd w;
        repeat (n) begin
            w = random_word();
            w.cmd_valid = 1'b0;
            send_word(w);
        end
    endtask

    // Start one transfer and clock it through to STOP.
    task automatic run_xfer(input logic op, input logic [7:0] dev, input logic [7:0] regb,
                            input logic [7:0] total, input int nack_slot,
                            input int noise_pct, input int busy_cmd_pct);
        t_cmd w;
        w = random_word();
        w.cmd_valid = 1'b1;
        w.opcode = op;
        w.device_address = dev;
        w.register_address = regb;
        w.byte_total = total;
        send_word(w);
        while (ph_q != PH_IDLE) begin
            w = random_word();
            // Commands offered mid-transfer must be ignored.
            w.cmd_valid = ($urandom_range(99) < busy_cmd_pct);
            w.sda_in = device_sda(nack_slot, noise_pct);
            send_word(w);
        end
    endtask

    // Stop sending and hold until every predicted word has come back.
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pin_forecast.size() != 0);
    endtask

    // Write a half-period register; only called with the bus idle.
    task automatic write_half(input logic [CFG_INDEX_BITS-1:0] idx, input logic [15:0] val);
        drain_results();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_WRITE_HALF) wr_half = val;
        else rd_half = val;
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Idle bus and one address byte at the reset half period.
    task automatic test_reset_defaults();
        idle_ticks(3);
        run_xfer(OP_WRITE, 8'hA4, 8'h10, 8'd1, ACK_ADDR_WR, 0, 0);
    endtask

    task automatic test_write_paths();
        write_half(CFG_WRITE_HALF, 16'd1);
        write_half(CFG_READ_HALF, 16'd1);
        // Zero count acts as one byte; the NACKed byte still counts.
        run_xfer(OP_WRITE, 8'h7E, 8'hC3, 8'd0, ACK_DATA0, 0, 0);
    endtask

    task automatic test_read_paths();
        // NACK on the read address is ignored; the byte still comes in.
        run_xfer(OP_READ, 8'h91, 8'h0F, 8'd1, ACK_ADDR_RD, 0, 0);
    endtask

    task automatic test_busy_commands();
        run_xfer(OP_WRITE, 8'h42, 8'h33, 8'd2, ACK_ADDR_WR, 0, 100);
    endtask

    task automatic test_half_periods();
        // Zero acts as one.
        write_half(CFG_WRITE_HALF, 16'd0);
        write_half(CFG_READ_HALF, 16'd0);
        run_xfer(OP_READ, 8'h6E, 8'hF0, 8'd3, ACK_REG, 0, 0);
        // Largest transmit half period with the bus left idle.
        write_half(CFG_WRITE_HALF, 16'hFFFF);
        idle_ticks(6);
        write_half(CFG_WRITE_HALF, 16'd1);
        write_half(CFG_READ_HALF, 16'd1);
    endtask

    // Short transfers with random content; many get NACKs or noise.
    task automatic test_random_traffic(input int gap, input int stall, input int n_xfers);
        int       pick;
        int       nack_slot;
        int       noise;
        logic [7:0] total;
        gap_pct   = gap;
        stall_pct = stall;
        write_half(CFG_WRITE_HALF, 16'($urandom_range(1)));
        write_half(CFG_READ_HALF, 16'($urandom_range(2)));
        repeat (n_xfers) begin
            pick = $urandom_range(99);
            if (pick < 15) total = 8'd0;
            else total = 8'($urandom_range(1, 2));
            nack_slot = ($urandom_range(1) == 0) ? int'($urandom_range(3)) : ACK_NONE;
            noise = ($urandom_range(4) == 0) ? 30 : 3;
            idle_ticks($urandom_range(3));
            run_xfer(1'($urandom_range(1)), 8'($urandom), 8'($urandom), total,
                     nack_slot, noise, 30);
        end
        // Let the pipe run dry before the next setting.
        drain_results();
    endtask

    // ------------------------------------------------------------------
    // Receiver stalls, result checking and the cycle limit
    // ------------------------------------------------------------------
    always @(posedge i_clk) m_axis_tready <= ($urandom_range(99) >= stall_pct);

    task automatic check_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge i_clk) begin : result_check
        t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pin_forecast.size() == 0) begin
                $error("result word %0h with no prediction pending", m_axis_tdata);
                fail_count++;
            end else begin
                want = pin_forecast.pop_front();
                check_field("scl_out", 8'(want.scl_out), 8'(m_axis_tdata[0]));
                check_field("sda_out", 8'(want.sda_out), 8'(m_axis_tdata[1]));
                check_field("sda_drive_enable", 8'(want.sda_drive_enable),
                            8'(m_axis_tdata[2]));
                check_field("busy_res", 8'(want.busy_res), 8'(m_axis_tdata[3]));
                check_field("data_request", 8'(want.data_request), 8'(m_axis_tdata[4]));
                check_field("read_byte_out", want.read_byte_out, m_axis_tdata[12:5]);
                check_field("read_valid", 8'(want.read_valid), 8'(m_axis_tdata[13]));
                check_field("done_res", 8'(want.done_res), 8'(m_axis_tdata[14]));
                check_field("bytes_done", want.bytes_done, m_axis_tdata[22:15]);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    initial begin : main
        int waited;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_defaults();
        test_write_paths();
        test_read_paths();
        test_busy_commands();
        test_half_periods();
        test_random_traffic(0, 0, 1);
        test_random_traffic(52, 0, 1);
        test_random_traffic(0, 52, 1);
        test_random_traffic(27, 27, 1);

        // Wait out the last results, bounded, then a few quiet cycles.
        s_axis_tvalid <= 1'b0;
        waited = 0;
        while (pin_forecast.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        if (pin_forecast.size() != 0) begin
            $error("%0d predicted result words never arrived", pin_forecast.size());
            fail_count++;
        end
        repeat (4) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
